/* sv/mdr_pkg.sv */
// Package for the motor duty ramp block: field widths, reset values, ramp phase codes,
// configuration register indexes and the duty limit and clamp functions.
// It depends on nothing else.
package mdr_pkg;

	localparam int DUTY_W = 14;
	localparam int PCT_W = 7;
	localparam int PERIOD_W = 18;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 18;
	localparam int CALC_W = 18;

	localparam int RAMP_STEPS_DEF = 100;
	localparam int TICK_COUNT_BITS_DEF = 18;

	localparam logic [PERIOD_W-1:0] RAMP_TICKS_RST = 18'd80000;
	localparam logic [PERIOD_W-1:0] REV_TICKS_RST = 18'd100000;
	localparam logic [PCT_W-1:0] MIN_PCT_RST = 7'd10;
	localparam logic [PCT_W-1:0] MAX_PCT_RST = 7'd90;
	localparam logic [DUTY_W-1:0] DUTY_RST = 14'd1000;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_PER_PCT = 14'd100;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SAME = 2'd1,
		PH_DOWN = 2'd2,
		PH_UP   = 2'd3
	} ramp_phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RAMP_TICKS = 2'd0,
		CFG_REV_TICKS  = 2'd1,
		CFG_MIN_PCT    = 2'd2,
		CFG_MAX_PCT    = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_MOTOR = 1'b0,
		CMD_TICK  = 1'b1
	} command_t;

	// Percent limit saturated at full duty, scaled to hundredths.
	function automatic logic [DUTY_W-1:0] lim_percent(input logic [PCT_W-1:0] p);
		logic [PCT_W-1:0] s;
		s = (p > PCT_FULL) ? PCT_FULL : p;
		return DUTY_W'(s) * DUTY_PER_PCT;
	endfunction

	// The low limit wins first, then the high limit.
	function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [CALC_W-1:0] v,
			input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] hi);
		logic signed [CALC_W-1:0] lo_s;
		logic signed [CALC_W-1:0] hi_s;
		lo_s = $signed({{(CALC_W-DUTY_W){1'b0}}, lo});
		hi_s = $signed({{(CALC_W-DUTY_W){1'b0}}, hi});
		if (v <= lo_s) begin
			return lo;
		end else if (v >= hi_s) begin
			return hi;
		end
		return v[DUTY_W-1:0];
	endfunction

endpackage

/* sv/motor_duty_ramp_with_reversal.sv */
// Top level of the motor duty ramp: input register, ramp state, result valid and
// configuration registers. It depends on mdr_pkg.
//
// Every input word, a motor command or a time tick, yields one result word carrying the duty
// in hundredths of a percent, the enable and direction pin levels and the ramp busy flag.
// The block takes one word per clock cycle while results are taken: a word sits in the input
// register, and once the result register is free its command or tick logic updates the ramp
// state, which doubles as the result register. The throughput limit is the single state update
// per cycle; while a result waits to be taken, one more word is still accepted into the input
// register. A ramped command's step is the duty difference, on a reversal both duties less
// twice the low limit, over RAMP_STEPS, as an exact reciprocal multiply in the state update.
module motor_duty_ramp_with_reversal #(
	parameter int RAMP_STEPS = mdr_pkg::RAMP_STEPS_DEF,
	parameter int TICK_COUNT_BITS = mdr_pkg::TICK_COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mdr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic [mdr_pkg::PCT_W-1:0] speed_percent,
	input  logic enable_request,
	input  logic direction_request,
	input  logic ramp_request,
	output logic out_valid,
	input  logic out_ready,
	output logic [mdr_pkg::DUTY_W-1:0] duty_hundredths,
	output logic enable_out,
	output logic direction_out,
	output logic ramp_busy
);
	import mdr_pkg::*;

	localparam int SL_W = $clog2(RAMP_STEPS + 1);
	localparam int STEP_W = 16;
	localparam int MAG_W = 15;
	localparam int RECIP_W = 17;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int DIV_SH = MAG_W + $clog2(RAMP_STEPS);
	localparam longint RECIP_L = ((64'd1 << DIV_SH) + RAMP_STEPS - 1) / RAMP_STEPS;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam int CMP_W = (TICK_COUNT_BITS > PERIOD_W) ? TICK_COUNT_BITS : PERIOD_W;
	localparam logic [SL_W-1:0] STEPS_FULL = SL_W'(RAMP_STEPS);

	logic [PERIOD_W-1:0] ramp_ticks_q;
	logic [PERIOD_W-1:0] rev_ticks_q;
	logic [PCT_W-1:0] min_pct_q;
	logic [PCT_W-1:0] max_pct_q;

	logic valid_s1;
	logic command_s1;
	logic [PCT_W-1:0] speed_s1;
	logic enable_s1;
	logic direction_s1;
	logic ramp_s1;

	logic [DUTY_W-1:0] duty_now_q;
	logic [DUTY_W-1:0] duty_target_q;
	logic signed [STEP_W-1:0] step_size_q;
	logic [SL_W-1:0] steps_left_q;
	logic [TICK_COUNT_BITS-1:0] tick_count_q;
	ramp_phase_t phase_q;
	logic dir_now_q;
	logic dir_target_q;
	logic enable_q;
	logic out_valid_q;

	logic advance;
	logic [DUTY_W-1:0] duty_now_d;
	logic [DUTY_W-1:0] duty_target_d;
	logic signed [STEP_W-1:0] step_size_d;
	logic [SL_W-1:0] steps_left_d;
	logic [TICK_COUNT_BITS-1:0] tick_count_d;
	ramp_phase_t phase_d;
	logic dir_now_d;
	logic dir_target_d;
	logic enable_d;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_ticks_q <= RAMP_TICKS_RST;
			rev_ticks_q <= REV_TICKS_RST;
			min_pct_q <= MIN_PCT_RST;
			max_pct_q <= MAX_PCT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAMP_TICKS: ramp_ticks_q <= cfg_data;
				CFG_REV_TICKS: rev_ticks_q <= cfg_data;
				CFG_MIN_PCT: min_pct_q <= cfg_data[PCT_W-1:0];
				CFG_MAX_PCT: max_pct_q <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			speed_s1 <= speed_percent;
			enable_s1 <= enable_request;
			direction_s1 <= direction_request;
			ramp_s1 <= ramp_request;
		end
	end

	always_comb begin
		logic [DUTY_W-1:0] lo;
		logic [DUTY_W-1:0] hi;
		logic signed [CALC_W-1:0] lo_s;
		logic signed [CALC_W-1:0] now_s;
		logic signed [CALC_W-1:0] tgt_s;
		logic signed [CALC_W-1:0] step_s;
		logic signed [CALC_W-1:0] dividend;
		logic signed [CALC_W-1:0] sum_v;
		logic [DUTY_W-1:0] tgt_new;
		logic div_neg;
		logic [MAG_W-1:0] mag;
		logic [PROD_W-1:0] prod;
		logic [MAG_W-1:0] quot;
		logic [PERIOD_W-1:0] period;
		logic [TICK_COUNT_BITS-1:0] tick_next;
		ramp_phase_t ph;

		lo = lim_percent(min_pct_q);
		hi = lim_percent(max_pct_q);
		lo_s = $signed({{(CALC_W-DUTY_W){1'b0}}, lo});
		now_s = $signed({{(CALC_W-DUTY_W){1'b0}}, duty_now_q});
		tgt_s = $signed({{(CALC_W-DUTY_W){1'b0}}, duty_target_q});
		step_s = CALC_W'(step_size_q);

		duty_now_d = duty_now_q;
		duty_target_d = duty_target_q;
		step_size_d = step_size_q;
		steps_left_d = steps_left_q;
		tick_count_d = tick_count_q;
		phase_d = phase_q;
		dir_now_d = dir_now_q;
		dir_target_d = dir_target_q;
		enable_d = enable_q;

		tgt_new = clamp_duty($signed(CALC_W'(speed_s1) * CALC_W'(DUTY_PER_PCT)), lo, hi);
		if (direction_s1 == dir_now_q) begin
			dividend = $signed({{(CALC_W-DUTY_W){1'b0}}, tgt_new}) - now_s;
		end else begin
			dividend = now_s + $signed({{(CALC_W-DUTY_W){1'b0}}, tgt_new}) - (lo_s <<< 1);
		end
		div_neg = dividend < 0;
		mag = div_neg ? MAG_W'(-dividend) : MAG_W'(dividend);
		prod = PROD_W'(mag) * PROD_W'(RECIP);
		quot = MAG_W'(prod >> DIV_SH);

		period = (phase_q == PH_SAME) ? ramp_ticks_q : rev_ticks_q;
		if (period == '0) begin
			period = PERIOD_W'(1);
		end
		tick_next = tick_count_q + TICK_COUNT_BITS'(1);
		sum_v = now_s + step_s;
		ph = phase_q;

		if (command_s1 == CMD_MOTOR) begin
			enable_d = enable_s1;
			duty_target_d = tgt_new;
			dir_target_d = direction_s1;
			tick_count_d = '0;
			if (!ramp_s1) begin
				duty_now_d = tgt_new;
				dir_now_d = direction_s1;
				phase_d = PH_IDLE;
				steps_left_d = '0;
				step_size_d = '0;
			end else begin
				step_size_d = div_neg ? -$signed(STEP_W'(quot)) : $signed(STEP_W'(quot));
				steps_left_d = STEPS_FULL;
				phase_d = (direction_s1 == dir_now_q) ? PH_SAME : PH_DOWN;
			end
		end else if (phase_q != PH_IDLE) begin
			if (CMP_W'(tick_next) >= CMP_W'(period) || tick_next == '0) begin
				tick_count_d = '0;
				if (steps_left_q == '0) begin
					duty_now_d = duty_target_q;
					dir_now_d = dir_target_q;
					phase_d = PH_IDLE;
					step_size_d = '0;
				end else begin
					steps_left_d = steps_left_q - SL_W'(1);
					if (phase_q == PH_SAME) begin
						duty_now_d = clamp_duty(sum_v, lo, hi);
					end else begin
						if (phase_q == PH_DOWN && now_s <= lo_s + (step_s <<< 1)) begin
							dir_now_d = dir_target_q;
							ph = PH_UP;
						end
						phase_d = ph;
						if (ph == PH_DOWN) begin
							duty_now_d = clamp_duty(now_s - step_s, lo, hi);
						end else begin
							if (sum_v >= tgt_s) begin
								steps_left_d = '0;
							end
							duty_now_d = clamp_duty(sum_v, lo, hi);
						end
					end
				end
			end else begin
				tick_count_d = tick_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_now_q <= DUTY_RST;
			duty_target_q <= DUTY_RST;
			step_size_q <= '0;
			steps_left_q <= '0;
			tick_count_q <= '0;
			phase_q <= PH_IDLE;
			dir_now_q <= 1'b0;
			dir_target_q <= 1'b0;
			enable_q <= 1'b0;
		end else if (advance) begin
			duty_now_q <= duty_now_d;
			duty_target_q <= duty_target_d;
			step_size_q <= step_size_d;
			steps_left_q <= steps_left_d;
			tick_count_q <= tick_count_d;
			phase_q <= phase_d;
			dir_now_q <= dir_now_d;
			dir_target_q <= dir_target_d;
			enable_q <= enable_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign duty_hundredths = duty_now_q;
	assign enable_out = enable_q;
	assign direction_out = dir_now_q;
	assign ramp_busy = (phase_q != PH_IDLE);

`ifndef ASSERT_OFF
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> steps_left_q == '0 && step_size_q == '0 && tick_count_q == '0)
		else $error("idle phase with leftover ramp state");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_now_q <= DUTY_FULL && duty_target_q <= DUTY_FULL)
		else $error("duty beyond full scale");

	a_ramp_start: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE && !(advance && command_s1 == CMD_MOTOR) |=> phase_q == PH_IDLE)
		else $error("ramp started without a motor command");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(duty_now_q) && $stable(phase_q)
			&& $stable(dir_now_q))
		else $error("ramp state moved while a result word was stalled");
`endif

endmodule

/* test/tb_motor_duty_ramp_with_reversal.sv */
`timescale 1ns / 1ps
// Testbench for motor_duty_ramp_with_reversal: random and directed command and tick words
// checked word by word against a scoreboard that tracks the ramp. Depends on mdr_pkg.
import mdr_pkg::*;

typedef struct packed {
	logic [DUTY_W-1:0] duty;
	logic enable;
	logic direction;
	logic busy;
} drive_state_t;

class duty_ramp_scoreboard;
	localparam int STEPS = RAMP_STEPS_DEF;

	logic [PERIOD_W-1:0] ramp_ticks;
	logic [PERIOD_W-1:0] rev_ticks;
	logic [PCT_W-1:0] min_pct;
	logic [PCT_W-1:0] max_pct;
	logic [DUTY_W-1:0] duty_now;
	logic [DUTY_W-1:0] duty_goal;
	int step_size;
	logic [7:0] steps_left;
	logic [PERIOD_W-1:0] tick_cnt;
	ramp_phase_t phase;
	logic dir_now;
	logic dir_goal;
	logic en_now;
	drive_state_t expected_pins[$];
	int errors;

	function new();
		ramp_ticks = RAMP_TICKS_RST;
		rev_ticks = REV_TICKS_RST;
		min_pct = MIN_PCT_RST;
		max_pct = MAX_PCT_RST;
		duty_now = DUTY_RST;
		duty_goal = DUTY_RST;
		step_size = 0;
		steps_left = '0;
		tick_cnt = '0;
		phase = PH_IDLE;
		dir_now = 1'b0;
		dir_goal = 1'b0;
		en_now = 1'b0;
		errors = 0;
	endfunction

	function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_RAMP_TICKS: ramp_ticks = data;
			CFG_REV_TICKS: rev_ticks = data;
			CFG_MIN_PCT: min_pct = data[PCT_W-1:0];
			CFG_MAX_PCT: max_pct = data[PCT_W-1:0];
			default: ;
		endcase
	endfunction

	function int pct_to_hundredths(logic [PCT_W-1:0] p);
		int q;
		q = int'(p);
		if (q > 100)
			q = 100;
		return q * 100;
	endfunction

	function logic [DUTY_W-1:0] clamp_hundredths(int v);
		int lo;
		int hi;
		lo = pct_to_hundredths(min_pct);
		hi = pct_to_hundredths(max_pct);
		if (v <= lo)
			return lo[DUTY_W-1:0];
		if (v >= hi)
			return hi[DUTY_W-1:0];
		return v[DUTY_W-1:0];
	endfunction

	function void advance_ramp();
		int lo;
		int d;
		int g;
		int v;
		lo = pct_to_hundredths(min_pct);
		d = int'(duty_now);
		g = int'(duty_goal);
		if (steps_left == 0) begin
			duty_now = duty_goal;
			dir_now = dir_goal;
			phase = PH_IDLE;
			step_size = 0;
			return;
		end
		steps_left = steps_left - 8'd1;
		if (phase == PH_SAME) begin
			duty_now = clamp_hundredths(d + step_size);
			return;
		end
		if (phase == PH_DOWN && d <= lo + 2 * step_size) begin
			dir_now = dir_goal;
			phase = PH_UP;
		end
		if (phase == PH_DOWN) begin
			duty_now = clamp_hundredths(d - step_size);
		end else begin
			v = d + step_size;
			if (v >= g)
				steps_left = '0;
			duty_now = clamp_hundredths(v);
		end
	endfunction

	function void note_word(command_t cmd, logic [PCT_W-1:0] sp, logic en, logic dir,
			logic rmp);
		int lo;
		int d;
		int g;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] nxt;
		drive_state_t pins;
		if (cmd == CMD_MOTOR) begin
			lo = pct_to_hundredths(min_pct);
			en_now = en;
			g = int'(sp);
			duty_goal = clamp_hundredths(g * 100);
			dir_goal = dir;
			tick_cnt = '0;
			d = int'(duty_now);
			g = int'(duty_goal);
			if (!rmp) begin
				duty_now = duty_goal;
				dir_now = dir;
				phase = PH_IDLE;
				steps_left = '0;
				step_size = 0;
			end else if (dir == dir_now) begin
				step_size = (g - d) / STEPS;
				steps_left = 8'(STEPS);
				phase = PH_SAME;
			end else begin
				step_size = (d + g - 2 * lo) / STEPS;
				steps_left = 8'(STEPS);
				phase = PH_DOWN;
			end
		end else if (phase != PH_IDLE) begin
			period = (phase == PH_SAME) ? ramp_ticks : rev_ticks;
			nxt = tick_cnt + 1'b1;
			if (period == 0)
				period = PERIOD_W'(1);
			if (nxt >= period || nxt == 0) begin
				tick_cnt = '0;
				advance_ramp();
			end else begin
				tick_cnt = nxt;
			end
		end
		pins.duty = duty_now;
		pins.enable = en_now;
		pins.direction = dir_now;
		pins.busy = (phase != PH_IDLE);
		expected_pins.push_back(pins);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_word(drive_state_t got);
		drive_state_t want;
		if (expected_pins.size() == 0) begin
			errors++;
			$display("%0t: word with nothing expected, actual duty %0d enable %0b dir %0b busy %0b",
				$time, got.duty, got.enable, got.direction, got.busy);
			return;
		end
		want = expected_pins.pop_front();
		compare_field("duty_hundredths", want.duty, got.duty);
		compare_field("enable_out", want.enable, got.enable);
		compare_field("direction_out", want.direction, got.direction);
		compare_field("ramp_busy", want.busy, got.busy);
	endfunction

	function int pending();
		return expected_pins.size();
	endfunction
endclass

module tb_motor_duty_ramp_with_reversal;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_reg_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	command_t command;
	logic [PCT_W-1:0] speed_percent;
	logic enable_request;
	logic direction_request;
	logic ramp_request;
	logic out_valid;
	logic out_ready;
	logic [DUTY_W-1:0] duty_hundredths;
	logic enable_out;
	logic direction_out;
	logic ramp_busy;

	duty_ramp_scoreboard sb;
	bit steady;
	bit hold_req;
	int hold_left;
	int stalled;
	int words_sent;

	motor_duty_ramp_with_reversal dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.speed_percent(speed_percent),
		.enable_request(enable_request),
		.direction_request(direction_request),
		.ramp_request(ramp_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.duty_hundredths(duty_hundredths),
		.enable_out(enable_out),
		.direction_out(direction_out),
		.ramp_busy(ramp_busy)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_word(command, speed_percent, enable_request, direction_request, ramp_request);
		if (arst_n && out_valid && out_ready)
			sb.check_word({duty_hundredths, enable_out, direction_out, ramp_busy});
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			stalled = 0;
		end else begin
			stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_word(input command_t c, input logic [PCT_W-1:0] sp, input logic en,
			input logic dir, input logic rmp);
		if (!steady) begin
			while ($urandom_range(99) < 15) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		command <= c;
		speed_percent <= sp;
		enable_request <= en;
		direction_request <= dir;
		ramp_request <= rmp;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	task automatic send_ticks(input int unsigned count);
		repeat (count)
			send_word(CMD_TICK, PCT_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	function automatic logic [PCT_W-1:0] rand_speed();
		if ($urandom_range(19) == 0)
			return PCT_W'($urandom_range(127, 101));
		return PCT_W'($urandom_range(100));
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(input logic [PERIOD_W-1:0] ramp_t, input logic [PERIOD_W-1:0] rev_t,
			input logic [PCT_W-1:0] lo_pct, input logic [PCT_W-1:0] hi_pct);
		write_reg(CFG_RAMP_TICKS, ramp_t);
		write_reg(CFG_REV_TICKS, rev_t);
		write_reg(CFG_MIN_PCT, CFG_DATA_W'(lo_pct));
		write_reg(CFG_MAX_PCT, CFG_DATA_W'(hi_pct));
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly a command followed by a short or long run of ticks, with some bursts of
	// back-to-back commands and loose ticks mixed in.
	task automatic run_ramps(input int unsigned target);
		int unsigned start;
		int unsigned kind;
		int unsigned n;
		start = words_sent;
		while (words_sent - start < target) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				send_word(CMD_MOTOR, rand_speed(), 1'($urandom), 1'($urandom),
					$urandom_range(99) < 80);
				if ($urandom_range(3) == 0)
					n = $urandom_range(12);
				else
					n = $urandom_range(320, 60);
			end else if (kind < 90) begin
				n = 0;
				repeat ($urandom_range(4, 1))
					send_word(CMD_MOTOR, rand_speed(), 1'($urandom), 1'($urandom),
						1'($urandom));
			end else begin
				n = $urandom_range(20);
			end
			if (n > target - (words_sent - start))
				n = target - (words_sent - start);
			send_ticks(n);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RAMP_TICKS;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_MOTOR;
		speed_percent = '0;
		enable_request = 1'b0;
		direction_request = 1'b0;
		ramp_request = 1'b0;
		out_ready = 1'b0;
		steady = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		stalled = 0;
		words_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a tick while idle, clamping at both ends, a same-direction ramp,
		// a reversal that restarts it and a direct command that cuts it short.
		send_word(CMD_TICK, 7'd127, 1'b1, 1'b1, 1'b1);
		send_word(CMD_MOTOR, 7'd0, 1'b1, 1'b0, 1'b0);
		send_word(CMD_MOTOR, 7'd100, 1'b0, 1'b1, 1'b0);
		send_word(CMD_MOTOR, 7'd127, 1'b1, 1'b1, 1'b0);
		send_word(CMD_MOTOR, 7'd50, 1'b1, 1'b1, 1'b1);
		send_ticks(3);
		send_word(CMD_MOTOR, 7'd20, 1'b1, 1'b0, 1'b1);
		send_ticks(3);
		send_word(CMD_MOTOR, 7'd30, 1'b0, 1'b0, 1'b0);
		drain();

		configure(18'd1, 18'd1, 7'd0, 7'd100);
		send_word(CMD_MOTOR, 7'd0, 1'b1, 1'b0, 1'b0);
		send_word(CMD_MOTOR, 7'd127, 1'b1, 1'b1, 1'b1);
		send_ticks(105);
		run_ramps(150);
		hold_req = 1'b1;
		run_ramps(200);
		drain();

		configure(18'd0, 18'd2, 7'd127, 7'd0);
		run_ramps(150);
		drain();

		configure(18'h3FFFF, 18'd1, 7'd20, 7'd80);
		run_ramps(150);
		drain();

		configure(18'd2, 18'd3, 7'd15, 7'd85);
		steady = 1'b1;
		run_ramps(250);
		steady = 1'b0;
		run_ramps(250);
		drain();

		configure(18'd1, 18'd0, 7'd30, 7'd127);
		run_ramps(180);
		drain();

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			if (sb.pending() != 0)
				$display("%0t: %0d expected words never arrived", $time, sb.pending());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
